// ===== design/cltp_pkg.sv =====
// Shared types and constants for the CAN text line parser.
// Used by cltp_front, cltp_queue, cltp_back and can_text_line_parser_core.
package cltp_pkg;

    // Line status codes; ST_OK also serves as "no error yet"
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_PREFIX = 3'd2,
        ST_MISSING   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_DATA  = 3'd5
    } status_t;

    // Field steps: prefix, id, dlc, eight data tokens, all tokens seen
    localparam logic [3:0] STEP_PREFIX    = 4'd0;
    localparam logic [3:0] STEP_ID        = 4'd1;
    localparam logic [3:0] STEP_LEN       = 4'd2;
    localparam logic [3:0] STEP_DATA0     = 4'd3;
    localparam logic [3:0] STEP_DATA_LAST = 4'd10;
    localparam logic [3:0] STEP_DONE      = 4'd11;

    // Phase inside an open token
    localparam logic [1:0] WP_START = 2'd0;  // nothing taken yet
    localparam logic [1:0] WP_SIGN  = 2'd1;  // sign taken, or high nibble of data byte
    localparam logic [1:0] WP_ZERO  = 2'd2;  // leading zero of id, or data byte complete
    localparam logic [1:0] WP_DIGIT = 2'd3;  // in the digits

    localparam int          PREFIX_LEN = 4;
    localparam logic [2:0]  PREFIX_END = 3'd4;
    localparam logic [7:0]  SIM_WORD [PREFIX_LEN] = '{8'h53, 8'h49, 8'h4D, 8'h20};

    localparam logic [3:0]  LEN_MAX = 4'd8;
    localparam logic [3:0]  LEN_SAT = 4'd9;

    // Queue depth between front and back, a power of two
    localparam int QDEPTH = 2;

    // Character classes worked out by the front
    typedef struct packed {
        logic       is_cr_nul;
        logic       is_space;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_dec;
        logic       is_sign;
        logic       is_minus;
        logic       is_lead;
        logic       is_x;
        logic       is_zero;
        logic [PREFIX_LEN-1:0] pmatch;
    } char_class_t;

    // One request in the queue
    typedef struct packed {
        char_class_t cls;
        logic        is_nl;   // newline: end the line, character not taken
        logic        forced;  // take the character, then end the line
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Per-line parser state
    typedef struct packed {
        logic [3:0]  field_step;
        logic [2:0]  prefix_pos;
        logic        in_word;
        logic [1:0]  word_pos;
        logic [31:0] id_acc;
        logic        id_minus;
        logic        number_stopped;
        logic [3:0]  len_acc;
        logic        len_minus;
        logic [63:0] byte_shift;
        logic [3:0]  high_nibble;
        status_t     err_code;
        logic        rest_ignored;
    } psr_state_t;

    localparam psr_state_t PSR_CLEAR = '{
        field_step:     STEP_PREFIX,
        prefix_pos:     3'd0,
        in_word:        1'b0,
        word_pos:       WP_START,
        id_acc:         32'd0,
        id_minus:       1'b0,
        number_stopped: 1'b0,
        len_acc:        4'd0,
        len_minus:      1'b0,
        byte_shift:     64'd0,
        high_nibble:    4'd0,
        err_code:       ST_OK,
        rest_ignored:   1'b0
    };

endpackage

// ===== design/cltp_front.sv =====
// Front of the parser: classifies each character and counts line length.
// Depends on cltp_pkg; feeds cltp_queue.
module cltp_front #(
    parameter int LINE_MAX = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          char_in,
    output cltp_pkg::item_t     item
);
    import cltp_pkg::*;

    localparam int CW = $clog2(LINE_MAX);
    localparam logic [CW-1:0] CNT_LAST = CW'(LINE_MAX - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] cnt_inc;
    logic          is_nl;
    logic          forced;
    logic          dec;
    logic          up_hex;
    logic          lo_hex;
    logic [7:0]    hex_off;

    // Classify the character
    always_comb
    begin
        dec     = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
        up_hex  = (char_in >= CH_UA) && (char_in <= CH_UF);
        lo_hex  = (char_in >= CH_LA) && (char_in <= CH_LF);
        hex_off = 8'd0;
        if (dec)
        begin
            hex_off = char_in - CH_ZERO;
        end
        else if (up_hex)
        begin
            hex_off = char_in - CH_UA + 8'd10;
        end
        else if (lo_hex)
        begin
            hex_off = char_in - CH_LA + 8'd10;
        end

        item.cls.is_cr_nul = (char_in == CH_CR) || (char_in == CH_NUL);
        item.cls.is_space  = (char_in == CH_SPACE);
        item.cls.is_hex    = dec || up_hex || lo_hex;
        item.cls.hex_val   = hex_off[3:0];
        item.cls.is_dec    = dec;
        item.cls.is_sign   = (char_in == CH_PLUS) || (char_in == CH_MINUS);
        item.cls.is_minus  = (char_in == CH_MINUS);
        item.cls.is_lead   = (char_in == CH_TAB) || (char_in == CH_VT) || (char_in == CH_FF);
        item.cls.is_x      = (char_in == CH_UX) || (char_in == CH_LX);
        item.cls.is_zero   = (char_in == CH_ZERO);
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            item.cls.pmatch[i] = (char_in == SIM_WORD[i]);
        end
        item.is_nl  = is_nl;
        item.forced = forced;
    end

    // Count characters of the line; force an end at the length limit
    always_comb
    begin
        is_nl    = (char_in == CH_NL);
        cnt_inc  = cnt_reg + 1'b1;
        forced   = !is_nl && (cnt_inc == CNT_LAST);
        cnt_next = cnt_reg;
        if (take)
        begin
            if (is_nl || forced)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/cltp_queue.sv =====
// Short request queue between front and back of the parser.
// Depends on cltp_pkg.
module cltp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cltp_pkg::item_t     wr_item,
    input  logic                pop,
    output cltp_pkg::item_t     rd_item,
    output cltp_pkg::q_stat_t   stat
);
    import cltp_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

    item_t          slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign stat.full  = (count_reg == QFULL);
    assign stat.empty = (count_reg == '0);
    assign rd_item    = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the stored requests
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== design/cltp_back.sv =====
// Back of the parser: field state machine and the result register.
// Depends on cltp_pkg; takes requests from cltp_queue.
module cltp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cltp_pkg::item_t     item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output cltp_pkg::status_t   status,
    output logic [31:0]         frame_id,
    output logic [3:0]          frame_len,
    output logic [63:0]         payload
);
    import cltp_pkg::*;

    function automatic psr_state_t close_token(psr_state_t s);
        psr_state_t t;
        t = s;
        if (s.field_step == STEP_LEN)
        begin
            if ((s.len_minus && s.len_acc != 4'd0) || s.len_acc > LEN_MAX)
            begin
                t.err_code = ST_BAD_LEN;
            end
        end
        else if (s.field_step >= STEP_DATA0 && s.field_step <= STEP_DATA_LAST)
        begin
            if (s.word_pos < WP_ZERO)
            begin
                t.err_code = ST_BAD_DATA;
            end
        end
        t.in_word        = 1'b0;
        t.word_pos       = WP_START;
        t.number_stopped = 1'b0;
        if (t.err_code == ST_OK && s.field_step < STEP_DONE)
        begin
            t.field_step = s.field_step + 4'd1;
        end
        return t;
    endfunction

    function automatic psr_state_t id_char(psr_state_t s, char_class_t k);
        psr_state_t t;
        t = s;
        if (!s.number_stopped)
        begin
            if (s.word_pos == WP_START && k.is_lead)
            begin
                // skip leading blanks
            end
            else if (s.word_pos == WP_START && k.is_sign)
            begin
                t.id_minus = k.is_minus;
                t.word_pos = WP_SIGN;
            end
            else if (s.word_pos <= WP_SIGN)
            begin
                if (k.is_hex)
                begin
                    t.id_acc   = {28'd0, k.hex_val};
                    t.word_pos = k.is_zero ? WP_ZERO : WP_DIGIT;
                end
                else
                begin
                    t.number_stopped = 1'b1;
                end
            end
            else if (s.word_pos == WP_ZERO)
            begin
                if (k.is_x)
                begin
                    t.word_pos = WP_DIGIT;
                end
                else if (k.is_hex)
                begin
                    t.id_acc   = {28'd0, k.hex_val};
                    t.word_pos = WP_DIGIT;
                end
                else
                begin
                    t.number_stopped = 1'b1;
                end
            end
            else
            begin
                if (k.is_hex)
                begin
                    t.id_acc = {s.id_acc[27:0], k.hex_val};
                end
                else
                begin
                    t.number_stopped = 1'b1;
                end
            end
        end
        return t;
    endfunction

    function automatic psr_state_t len_char(psr_state_t s, char_class_t k);
        psr_state_t t;
        t = s;
        if (!s.number_stopped)
        begin
            if (s.word_pos == WP_START && k.is_lead)
            begin
                // skip leading blanks
            end
            else if (s.word_pos == WP_START && k.is_sign)
            begin
                t.len_minus = k.is_minus;
                t.word_pos  = WP_SIGN;
            end
            else if (k.is_dec)
            begin
                // a digit after a nonzero value pushes it above eight: saturate
                t.len_acc  = (s.len_acc == 4'd0) ? k.hex_val : LEN_SAT;
                t.word_pos = WP_DIGIT;
            end
            else
            begin
                t.number_stopped = 1'b1;
            end
        end
        return t;
    endfunction

    function automatic psr_state_t data_char(psr_state_t s, char_class_t k);
        psr_state_t t;
        t = s;
        if (s.word_pos == WP_START)
        begin
            if (k.is_hex)
            begin
                t.high_nibble = k.hex_val;
                t.word_pos    = WP_SIGN;
            end
            else
            begin
                t.err_code = ST_BAD_DATA;
            end
        end
        else if (s.word_pos == WP_SIGN)
        begin
            if (k.is_hex)
            begin
                t.byte_shift = {s.byte_shift[55:0], s.high_nibble, k.hex_val};
                t.word_pos   = WP_ZERO;
            end
            else
            begin
                t.err_code = ST_BAD_DATA;
            end
        end
        return t;
    endfunction

    function automatic psr_state_t take_char(psr_state_t s, char_class_t k);
        psr_state_t t;
        t = s;
        if (s.err_code != ST_OK || s.rest_ignored)
        begin
            // line already decided
        end
        else if (k.is_cr_nul)
        begin
            t.rest_ignored = 1'b1;
        end
        else if (s.field_step == STEP_PREFIX)
        begin
            if (s.prefix_pos < PREFIX_END && k.pmatch[s.prefix_pos[1:0]])
            begin
                t.prefix_pos = s.prefix_pos + 3'd1;
                if (t.prefix_pos == PREFIX_END)
                begin
                    t.field_step = STEP_ID;
                end
            end
            else
            begin
                t.err_code = ST_NO_PREFIX;
            end
        end
        else if (s.field_step >= STEP_DONE)
        begin
            // tokens past the tenth are dropped
        end
        else if (k.is_space)
        begin
            if (s.in_word)
            begin
                t = close_token(s);
            end
        end
        else
        begin
            if (!s.in_word)
            begin
                t.in_word        = 1'b1;
                t.word_pos       = WP_START;
                t.number_stopped = 1'b0;
            end
            if (s.field_step == STEP_ID)
            begin
                t = id_char(t, k);
            end
            else if (s.field_step == STEP_LEN)
            begin
                t = len_char(t, k);
            end
            else
            begin
                t = data_char(t, k);
            end
        end
        return t;
    endfunction

    psr_state_t  state_reg;
    psr_state_t  state_next;
    psr_state_t  s_take;
    psr_state_t  s_close;
    logic        line_end;
    status_t     st;

    logic        out_valid_reg;
    logic        out_valid_next;
    status_t     status_reg;
    logic [31:0] id_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;

    // Pop whenever the result register is free or being drained
    assign pop = q_valid && (!out_valid_reg || out_ready);

    // Update the line state; on a line end, close it and work out the status
    always_comb
    begin
        s_take = state_reg;
        if (!item.is_nl)
        begin
            s_take = take_char(state_reg, item.cls);
        end
        s_close = s_take;
        if (s_take.in_word && s_take.err_code == ST_OK)
        begin
            s_close = close_token(s_take);
        end
        line_end = item.is_nl || item.forced;

        if (s_close.err_code != ST_OK)
        begin
            st = s_close.err_code;
        end
        else if (s_close.field_step == STEP_PREFIX && s_close.prefix_pos == 3'd0)
        begin
            st = ST_EMPTY;
        end
        else if (s_close.field_step == STEP_PREFIX)
        begin
            st = ST_NO_PREFIX;
        end
        else if (s_close.field_step < STEP_DONE)
        begin
            st = ST_MISSING;
        end
        else
        begin
            st = ST_OK;
        end

        state_next = state_reg;
        if (pop)
        begin
            state_next = line_end ? PSR_CLEAR : s_take;
        end

        out_valid_next = out_valid_reg;
        if (pop && line_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PSR_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register at a line end
    always_ff @(posedge clk)
    begin
        if (pop && line_end)
        begin
            status_reg <= st;
            if (st == ST_OK)
            begin
                id_reg   <= s_close.id_minus ? (32'd0 - s_close.id_acc) : s_close.id_acc;
                len_reg  <= s_close.len_acc;
                data_reg <= s_close.byte_shift;
            end
            else
            begin
                id_reg   <= 32'd0;
                len_reg  <= 4'd0;
                data_reg <= 64'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign frame_id  = id_reg;
    assign frame_len = len_reg;
    assign payload   = data_reg;

endmodule

// ===== design/can_text_line_parser_core.sv =====
// Top level of the CAN text line parser: front, request queue and back.
// Depends on cltp_pkg, cltp_front, cltp_queue and cltp_back.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_ready, char_in[7:0]             | to block
//   out     | out_valid, out_ready, status[2:0],           | from block
//           | frame_id[31:0], frame_len[3:0], payload[63:0]|
//
// One character is taken per cycle while the queue has room; a line-end
// result is read from its queue slot into the result register when the
// back pops it.
// The front counts characters and flags the line end; the back updates the
// field state once per request from a two-entry queue.
// Reset clears the counter, the queue and the line state; no clearing pass.
// A stalled result holds the back; the front keeps taking characters until
// the queue is full.
module can_text_line_parser_core #(
    parameter int LINE_MAX = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] frame_id,
    output logic [3:0]  frame_len,
    output logic [63:0] payload
);
    import cltp_pkg::*;

    item_t     f_item;
    item_t     q_item;
    q_stat_t   q_stat;
    logic      take;
    logic      pop;
    status_t   status_b;

    assign in_ready = !q_stat.full;
    assign take     = in_valid && in_ready;
    assign status   = status_b;

    cltp_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .char_in (char_in),
        .item    (f_item)
    );

    cltp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_item (f_item),
        .pop     (pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    cltp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_stat.empty),
        .item      (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status_b),
        .frame_id  (frame_id),
        .frame_len (frame_len),
        .payload   (payload)
    );

`ifndef SYNTHESIS
    // Queue is never full and empty at once
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // A request in the queue with a free result register is popped
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !out_valid) |-> pop)
        else $error("back stalled with free result register");

    // A failed line carries no frame
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_b != ST_OK) |->
        (frame_id == 32'd0 && frame_len == 4'd0 && payload == 64'd0))
        else $error("frame fields set on a failed line");

    // A good frame has a length of at most eight
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_b == ST_OK) |-> (frame_len <= LEN_MAX))
        else $error("frame length above eight");
`endif

endmodule
